// ===== src/ppe_pkg.sv =====
package ppe_pkg;

    // Input item commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Packing modes
    localparam logic [1:0] MODE_1BPP  = 2'd0;
    localparam logic [1:0] MODE_4BPP  = 2'd1;
    localparam logic [1:0] MODE_8BPP  = 2'd2;
    localparam logic [1:0] MODE_16BPP = 2'd3;

    // Result kinds
    localparam logic KIND_CURSOR = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  palette_index;
        logic [23:0] palette_rgb;
        logic [1:0]  bits_mode;
        logic [15:0] pixel_count;
        logic [2:0]  start_offset;
        logic [8:0]  cur_x;
        logic [7:0]  cur_y;
        logic [15:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ram_x;
        logic [8:0]  ram_y;
        logic [15:0] pixel;
        logic        last;
        logic        run_done;
    } t_out_item;

    // RGB888 to RGB565 by truncation
    function automatic logic [15:0] to565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

// ===== src/palette_pixel_expander.sv =====
// Palette pixel expander. Load items (cmd 0) write one entry of the RGB888
// palette without holding the input. A start item (cmd 1) sets the packing
// and pixel count and answers with one cursor result (ram_x = row, ram_y =
// MAX_COLUMN - column), which is registered and pushed once the output is
// free. A data item (cmd 2) yields its pixels one at a time through a single
// palette read port and pixel datapath: each pixel goes through index select
// and RAM read, then color build, then output, which waits out any output
// stall. The input is stalled until the last result of an item is in the
// output register. Data items after the run count reaches zero are dropped.
// Palette entries that were never loaded read back undefined.
module palette_pixel_expander #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_COLUMN      = 319
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ppe_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ppe_pkg::t_out_item o_out_item
);
    import ppe_pkg::*;

    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_out_free;
    logic      w_push;
    t_out_item w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;

    ppe_seq #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_COLUMN      (MAX_COLUMN)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_out_free (w_out_free),
        .o_push     (w_push),
        .o_res      (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("result pushed over a held item");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.kind == KIND_PIXEL && r_out_item.run_done)
        |-> r_out_item.last)
        else $error("run end pixel not marked last");

    a_cursor_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.kind == KIND_CURSOR)
        |-> (r_out_item.last && !r_out_item.run_done && r_out_item.pixel == 16'd0))
        else $error("malformed cursor result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.cmd == CMD_START) |=> o_in_stall)
        else $error("start item did not hold the input");

endmodule

// ===== src/ppe_palette_ram.sv =====
module ppe_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ppe_seq.sv =====
module ppe_seq #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_COLUMN      = 319
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ppe_pkg::t_in_item  i_in_item,
    input  logic               i_out_free,
    output logic               o_push,
    output ppe_pkg::t_out_item o_res
);
    import ppe_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_LOOK  = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_boff, n_boff;
    logic [2:0]  r_pos, n_pos;
    logic        r_more, n_more;
    logic [15:0] r_word, n_word;
    logic        r_idx_ok, n_idx_ok;
    t_out_item   r_res, n_res;

    logic        w_acc;
    logic [7:0]  w_byte;
    logic [7:0]  w_idx;
    logic        w_ld_ok;
    logic [23:0] w_rdata;
    logic [23:0] w_entry;
    logic [15:0] w_pix;
    logic [15:0] w_rem_dec;
    logic        w_more;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_byte     = r_word[7:0];
    assign w_ld_ok    = ({1'b0, i_in_item.palette_index} < 9'(PALETTE_ENTRIES));

    // Shift/select unit: palette index of the current pixel position
    always_comb begin
        case (r_mode)
            MODE_1BPP: w_idx = {7'd0, w_byte[3'd7 - r_pos]};
            MODE_4BPP: w_idx = (r_pos == 3'd0) ? {4'd0, w_byte[7:4]} : {4'd0, w_byte[3:0]};
            default:   w_idx = w_byte;
        endcase
    end

    ppe_palette_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && (i_in_item.cmd == CMD_LOAD) && w_ld_ok),
        .i_waddr (i_in_item.palette_index[AW-1:0]),
        .i_wdata (i_in_item.palette_rgb),
        .i_re    (r_state == S_FETCH),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Pixel color and countdown
    assign w_entry   = r_idx_ok ? w_rdata : 24'd0;
    assign w_rem_dec = r_rem - 16'd1;

    always_comb begin
        case (r_mode)
            MODE_1BPP:  w_pix = w_entry[15:0];
            MODE_16BPP: w_pix = r_word;
            default:    w_pix = to565(w_entry);
        endcase
    end

    always_comb begin
        case (r_mode)
            MODE_1BPP: w_more = (r_pos != 3'd7) && (w_rem_dec != 16'd0);
            MODE_4BPP: w_more = (r_pos == 3'd0) && (w_rem_dec != 16'd0);
            default:   w_more = 1'b0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_rem    = r_rem;
        n_boff   = r_boff;
        n_pos    = r_pos;
        n_more   = r_more;
        n_word   = r_word;
        n_idx_ok = r_idx_ok;
        n_res    = r_res;
        o_push   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_in_item.cmd == CMD_START) begin
                    n_mode       = i_in_item.bits_mode;
                    n_rem        = i_in_item.pixel_count;
                    n_boff       = i_in_item.start_offset;
                    n_more       = 1'b0;
                    n_res.kind   = KIND_CURSOR;
                    n_res.ram_x  = i_in_item.cur_y;
                    n_res.ram_y  = 9'(MAX_COLUMN) - i_in_item.cur_x;
                    n_res.pixel  = 16'd0;
                    n_res.last   = 1'b1;
                    n_res.run_done = 1'b0;
                    n_state      = S_PUSH;
                end else if (w_acc && i_in_item.cmd == CMD_DATA && r_rem != 16'd0) begin
                    n_word  = i_in_item.data_word;
                    n_pos   = (r_mode == MODE_4BPP) ? {2'd0, r_boff[0]} : r_boff;
                    n_boff  = 3'd0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_idx_ok = ({1'b0, w_idx} < 9'(PALETTE_ENTRIES));
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                n_rem          = w_rem_dec;
                n_pos          = r_pos + 3'd1;
                n_more         = w_more;
                n_res.kind     = KIND_PIXEL;
                n_res.ram_x    = 8'd0;
                n_res.ram_y    = 9'd0;
                n_res.pixel    = w_pix;
                n_res.last     = !w_more;
                n_res.run_done = (w_rem_dec == 16'd0);
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = r_more ? S_FETCH : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_1BPP;
            r_rem   <= 16'd0;
            r_boff  <= 3'd0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_rem   <= n_rem;
            r_boff  <= n_boff;
            r_more  <= n_more;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_idx_ok <= n_idx_ok;
        r_res    <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== dv/display_write_checker.sv =====
module display_write_checker #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_COLUMN      = 319
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  ppe_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  ppe_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_checked_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppe_pkg::*;

    // Shadow of the block's state
    logic [23:0] palette_shadow [256];
    logic [1:0]  run_mode;
    logic [15:0] pixels_left;
    logic [2:0]  first_pos;

    // Display writes still owed by the block, oldest first
    t_out_item display_write_q[$];

    // RGB888 -> RGB565, keep the top bits of each channel
    function automatic logic [15:0] rgb888_to_565(input logic [23:0] rgb);
        logic [23:0] packed565;
        packed565 = ((rgb & 24'hf80000) >> 8) | ((rgb & 24'h00fc00) >> 5) |
                    ((rgb & 24'h0000f8) >> 3);
        return packed565[15:0];
    endfunction

    // Out-of-range lookups read as zero
    function automatic logic [23:0] palette_lookup(input logic [7:0] idx);
        if (int'(idx) >= PALETTE_ENTRIES) begin
            return '0;
        end
        return palette_shadow[idx];
    endfunction

    // One pixel write, counted against the run
    task automatic queue_pixel(input logic [15:0] color);
        t_out_item w;
        pixels_left = pixels_left - 16'd1;
        w = '0;
        w.kind = KIND_PIXEL;
        w.pixel = color;
        w.run_done = (pixels_left == 16'd0);
        display_write_q.push_back(w);
    endtask

    // Writes caused by one accepted input item
    task automatic expand_item(input t_in_item it);
        t_out_item   w;
        int          depth_before;
        int          pos;
        logic [7:0]  data_byte;
        logic [23:0] native;
        depth_before = display_write_q.size();
        data_byte = it.data_word[7:0];
        case (it.cmd)
            CMD_LOAD: begin
                if (int'(it.palette_index) < PALETTE_ENTRIES) begin
                    palette_shadow[it.palette_index] = it.palette_rgb;
                end
            end
            CMD_START: begin
                run_mode = it.bits_mode;
                pixels_left = it.pixel_count;
                first_pos = it.start_offset;
                w = '0;
                w.kind = KIND_CURSOR;
                w.ram_x = it.cur_y;
                w.ram_y = 9'(MAX_COLUMN - int'(it.cur_x));
                display_write_q.push_back(w);
            end
            CMD_DATA: begin
                if (pixels_left != 16'd0) begin
                    case (run_mode)
                        MODE_1BPP: begin
                            // entries 0 and 1 hold native 565 colors
                            for (pos = int'(first_pos); pos < 8 && pixels_left != 16'd0;
                                 pos++) begin
                                native = palette_lookup({7'd0, data_byte[7 - pos]});
                                queue_pixel(native[15:0]);
                            end
                        end
                        MODE_4BPP: begin
                            if (!first_pos[0]) begin
                                queue_pixel(rgb888_to_565(palette_lookup({4'd0,
                                    data_byte[7:4]})));
                            end
                            if (pixels_left != 16'd0) begin
                                queue_pixel(rgb888_to_565(palette_lookup({4'd0,
                                    data_byte[3:0]})));
                            end
                        end
                        MODE_8BPP: begin
                            queue_pixel(rgb888_to_565(palette_lookup(data_byte)));
                        end
                        default: begin
                            queue_pixel(it.data_word);
                        end
                    endcase
                    // offset only applies to the first byte of a run
                    first_pos = '0;
                end
            end
            default: begin
            end
        endcase
        // mark the final write of this item
        if (display_write_q.size() > depth_before) begin
            w = display_write_q.pop_back();
            w.last = 1'b1;
            display_write_q.push_back(w);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // Predict on accepted input items, compare on accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            run_mode = MODE_1BPP;
            pixels_left = '0;
            first_pos = '0;
            display_write_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expand_item(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (display_write_q.size() == 0) begin
                    $error("unexpected result: kind %0b pixel 0x%0h", i_out_item.kind,
                           i_out_item.pixel);
                    o_fail_count++;
                end else begin
                    want = display_write_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_item.kind));
                    check_field("ram_x", 32'(want.ram_x), 32'(i_out_item.ram_x));
                    check_field("ram_y", 32'(want.ram_y), 32'(i_out_item.ram_y));
                    check_field("pixel", 32'(want.pixel), 32'(i_out_item.pixel));
                    check_field("last", 32'(want.last), 32'(i_out_item.last));
                    check_field("run_done", 32'(want.run_done), 32'(i_out_item.run_done));
                    o_checked_count++;
                end
            end
        end
        o_pending = display_write_q.size();
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppe_pkg::*;

    // cmd code the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int fail_count;
    int checked_count;
    int pending;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_left          = 0;
    int items_offered      = 0;
    int idle_mix[4]        = '{0, 64, 0, 38};
    int stall_mix[4]       = '{0, 0, 64, 38};

    palette_pixel_expander u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    display_write_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_checked_count (checked_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Output side: random stall, or a long hold when one is requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Random gap, then hold the item until it is taken
    task automatic offer_item(input t_in_item it, input bit counts);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (counts) begin
            items_offered++;
        end
    endtask

    // Unused fields carry random junk
    function automatic t_in_item random_item(input logic [1:0] cmd);
        t_in_item    it;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(t_in_item)-1:0];
        it.cmd = cmd;
        return it;
    endfunction

    function automatic t_in_item load_item(input logic [7:0] idx, input logic [23:0] rgb);
        t_in_item it;
        it = random_item(CMD_LOAD);
        it.palette_index = idx;
        it.palette_rgb = rgb;
        return it;
    endfunction

    function automatic t_in_item start_item(input logic [1:0] packing,
                                            input logic [15:0] count,
                                            input logic [2:0] offset,
                                            input logic [8:0] col, input logic [7:0] row);
        t_in_item it;
        it = random_item(CMD_START);
        it.bits_mode = packing;
        it.pixel_count = count;
        it.start_offset = offset;
        it.cur_x = col;
        it.cur_y = row;
        return it;
    endfunction

    function automatic t_in_item data_item(input logic [15:0] word);
        t_in_item it;
        it = random_item(CMD_DATA);
        it.data_word = word;
        return it;
    endfunction

    // Mostly complete runs with random content; some loads, junk and cut-off runs
    task automatic random_sequence();
        t_in_item it;
        int       pick;
        int       left;
        int       per;
        int       n_data;
        bit       first;
        pick = $urandom_range(99);
        if (pick < 8) begin
            offer_item(load_item(8'($urandom), 24'($urandom)), 1'b1);
        end else if (pick < 11) begin
            offer_item(random_item(CMD_UNUSED), 1'b0);
        end else begin
            it = random_item(CMD_START);
            pick = $urandom_range(99);
            if (pick < 80) begin
                it.pixel_count = 16'($urandom_range(24, 1));
            end else if (pick < 88) begin
                it.pixel_count = '0;
            end
            offer_item(it, 1'b1);
            left = int'(it.pixel_count);
            first = 1'b1;
            n_data = 0;
            while (left > 0 && n_data < 30 && !(n_data > 0 && $urandom_range(19) == 0)) begin
                offer_item(random_item(CMD_DATA), 1'b1);
                case (it.bits_mode)
                    MODE_1BPP: per = first ? 8 - int'(it.start_offset) : 8;
                    MODE_4BPP: per = (first && it.start_offset[0]) ? 1 : 2;
                    default:   per = 1;
                endcase
                left -= (per < left) ? per : left;
                first = 1'b0;
                n_data++;
            end
            // stray data once the run is over
            if (left == 0 && $urandom_range(3) == 0) begin
                offer_item(random_item(CMD_DATA), 1'b0);
            end
        end
    endtask

    initial begin
        int quota;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every entry so no lookup lands on an unloaded one
        for (int i = 0; i < 256; i++) begin
            offer_item(load_item(8'(i), 24'($urandom)), 1'b1);
        end

        // Directed: color extremes in the 1bpp entries and the top entry
        offer_item(load_item(8'd0, 24'h000000), 1'b1);
        offer_item(load_item(8'd1, 24'hffffff), 1'b1);
        offer_item(load_item(8'd255, 24'hffffff), 1'b1);
        // 1bpp: last bit of the first byte only, run ends mid-byte
        offer_item(start_item(MODE_1BPP, 16'd10, 3'd7, 9'd0, 8'd0), 1'b1);
        offer_item(data_item(16'h00a5), 1'b1);
        offer_item(data_item(16'hff5a), 1'b1);
        offer_item(data_item(16'h0080), 1'b1);
        // 4bpp: odd offset takes the low nibble only; data after done is dropped
        offer_item(start_item(MODE_4BPP, 16'd3, 3'd1, 9'd319, 8'd239), 1'b1);
        offer_item(data_item(16'h003c), 1'b1);
        offer_item(data_item(16'h00f0), 1'b1);
        offer_item(data_item(16'h0012), 1'b0);
        // 8bpp: offset has no effect, column past the edge wraps
        offer_item(start_item(MODE_8BPP, 16'd2, 3'd5, 9'd511, 8'd255), 1'b1);
        offer_item(data_item(16'h0000), 1'b1);
        offer_item(data_item(16'hffff), 1'b1);
        // 16bpp pass-through
        offer_item(start_item(MODE_16BPP, 16'd2, 3'd0, 9'd320, 8'd1), 1'b1);
        offer_item(data_item(16'hffff), 1'b1);
        offer_item(data_item(16'h0000), 1'b1);
        // zero-length run, then unused cmd
        offer_item(start_item(MODE_8BPP, 16'd0, 3'd0, 9'd100, 8'd50), 1'b1);
        offer_item(data_item(16'h00ff), 1'b0);
        offer_item(random_item(CMD_UNUSED), 1'b0);
        // max-length run cut short by a new start
        offer_item(start_item(MODE_16BPP, 16'hffff, 3'd0, 9'd256, 8'd128), 1'b1);
        offer_item(data_item(16'h1234), 1'b1);
        offer_item(start_item(MODE_1BPP, 16'd8, 3'd0, 9'd1, 8'd2), 1'b1);
        offer_item(data_item(16'h000f), 1'b1);

        // Long output hold while input keeps coming
        offer_item(start_item(MODE_1BPP, 16'd160, 3'd0, 9'd10, 8'd20), 1'b1);
        hold_left = 300;
        repeat (20) offer_item(random_item(CMD_DATA), 1'b1);

        // Random runs across the idle/stall mixes
        quota = items_offered;
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = idle_mix[phase];
            receiver_stall_pct = stall_mix[phase];
            quota += 50;
            while (items_offered < quota) random_sequence();
        end

        // Drain
        in_valid <= 1'b0;
        receiver_stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d items (palette loads, 1/4/8/16 bpp runs, stray data)",
                 items_offered);
        $display("Checked %0d writes over four sender/receiver idle mixes and a long hold",
                 checked_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ppe_pkg.sv
src/ppe_palette_ram.sv
src/ppe_seq.sv
src/palette_pixel_expander.sv
dv/display_write_checker.sv
dv/tb.sv
